@@ rtl/lcd_dot_timing_controller_core_defines.svh @@
// assertion macros shared by the lcd dot timing controller rtl
`ifndef LCD_DOT_TIMING_CONTROLLER_CORE_DEFINES_SVH
`define LCD_DOT_TIMING_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LDTC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ldtc assertion failed");

// next-cycle implication, checked out of reset
`define LDTC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ldtc assertion failed");

`endif

@@ rtl/ldtc_pkg.sv @@
// types, constants and helpers for the lcd dot timing controller
package ldtc_pkg;

  localparam int unsigned LINE_W = 8;
  localparam int unsigned DOT_W  = 9;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [DOT_W-1:0]  DOTS_PER_LINE = 9'd456;
  localparam logic [DOT_W-1:0]  SCAN_DOTS     = 9'd80;
  localparam logic [DOT_W-1:0]  VISIBLE_WIDTH = 9'd160;
  localparam logic [LINE_W-1:0] VISIBLE_LINES = 8'd144;
  localparam logic [DOT_W-1:0]  TOTAL_LINES   = 9'd154;
  localparam logic [DOT_W-1:0]  DOT_MAX       = 9'd511;

  // output mode codes
  localparam logic [1:0] MODE_CODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_CODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_CODE_SCAN   = 2'd2;
  localparam logic [1:0] MODE_CODE_DRAW   = 2'd3;

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_COMPARE_LINE   = 3'd0;
  localparam logic [2:0] REG_IRQ_HBLANK     = 3'd1;
  localparam logic [2:0] REG_IRQ_VBLANK     = 3'd2;
  localparam logic [2:0] REG_IRQ_SCAN       = 3'd3;
  localparam logic [2:0] REG_IRQ_COINCIDENT = 3'd4;

  typedef enum logic [3:0] {
    ST_HBLANK = 4'b0001,
    ST_VBLANK = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_DRAW   = 4'b1000
  } mode_e;

  typedef enum logic [4:0] {
    FP_TILE  = 5'b00001,
    FP_LOW   = 5'b00010,
    FP_HIGH  = 5'b00100,
    FP_SLEEP = 5'b01000,
    FP_PUSH  = 5'b10000
  } fetch_e;

  function automatic logic [1:0] mode_code(mode_e m);
    logic [1:0] c;
    c = MODE_CODE_HBLANK;
    unique case (m)
      ST_HBLANK: c = MODE_CODE_HBLANK;
      ST_VBLANK: c = MODE_CODE_VBLANK;
      ST_SCAN:   c = MODE_CODE_SCAN;
      ST_DRAW:   c = MODE_CODE_DRAW;
      default:   c = MODE_CODE_HBLANK;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/lcd_dot_timing_controller_core.sv @@
// lcd dot timing controller: mode sequence, line counter, interrupts and pixel cadence
// One dot transaction is taken per clock cycle whenever the result register is empty or
// being drained, so the sustained rate is one dot per cycle; the line and fetch state is
// updated in a single pass of logic at the input handshake and the result for that dot
// is held in the output register from the next cycle. Registers sit on a 5-bit APB-style port:
// compare_line at 0x00, then the hblank, vblank, scan and coincidence stat enables at
// 0x04, 0x08, 0x0c and 0x10 (bit 0). Write them only while no dot is in flight.
`include "lcd_dot_timing_controller_core_defines.svh"

module lcd_dot_timing_controller_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // dot channel
  input  logic                           dot_valid_i,
  output logic                           dot_ready_o,
  input  logic                           dot_enable_i,
  // result channel
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output logic [1:0]                     mode_o,
  output logic [ldtc_pkg::LINE_W-1:0]    line_o,
  output logic                           coincidence_o,
  output logic                           vblank_irq_o,
  output logic                           stat_irq_o,
  output logic                           pixel_valid_o,
  output logic [ldtc_pkg::LINE_W-1:0]    pixel_x_o,
  output logic [ldtc_pkg::LINE_W-1:0]    pixel_y_o,
  output logic                           frame_start_o,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ldtc_pkg::ADDR_W-1:0]    paddr,
  input  logic [ldtc_pkg::DATA_W-1:0]    pwdata,
  output logic [ldtc_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);

  // configuration
  logic [ldtc_pkg::LINE_W-1:0] compare_line_q;
  logic irq_hblank_q, irq_vblank_q, irq_scan_q, irq_coin_q;
  logic                        cfg_we;
  logic [2:0]                  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = paddr[ldtc_pkg::ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      compare_line_q <= '0;
      irq_hblank_q   <= 1'b0;
      irq_vblank_q   <= 1'b0;
      irq_scan_q     <= 1'b0;
      irq_coin_q     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ldtc_pkg::REG_COMPARE_LINE:   compare_line_q <= pwdata[ldtc_pkg::LINE_W-1:0];
        ldtc_pkg::REG_IRQ_HBLANK:     irq_hblank_q   <= pwdata[0];
        ldtc_pkg::REG_IRQ_VBLANK:     irq_vblank_q   <= pwdata[0];
        ldtc_pkg::REG_IRQ_SCAN:       irq_scan_q     <= pwdata[0];
        ldtc_pkg::REG_IRQ_COINCIDENT: irq_coin_q     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      ldtc_pkg::REG_COMPARE_LINE:   prdata[ldtc_pkg::LINE_W-1:0] = compare_line_q;
      ldtc_pkg::REG_IRQ_HBLANK:     prdata[0] = irq_hblank_q;
      ldtc_pkg::REG_IRQ_VBLANK:     prdata[0] = irq_vblank_q;
      ldtc_pkg::REG_IRQ_SCAN:       prdata[0] = irq_scan_q;
      ldtc_pkg::REG_IRQ_COINCIDENT: prdata[0] = irq_coin_q;
      default: ;
    endcase
  end

  // timing state
  ldtc_pkg::mode_e             mode_q, mode_d;
  ldtc_pkg::fetch_e            fetch_q, fetch_d;
  logic [ldtc_pkg::LINE_W-1:0] line_q, line_d;
  logic [ldtc_pkg::DOT_W-1:0]  dot_q, dot_d, dot_inc;
  logic [1:0]                  wait_q, wait_d;
  logic [ldtc_pkg::LINE_W-1:0] group_x_q, group_x_d;
  logic [3:0]                  pend_q, pend_d;
  logic                        coin_q, coin_d;

  // per-dot outputs
  logic                        vb, st, pv, fs;
  logic [ldtc_pkg::LINE_W-1:0] px, py;
  logic [ldtc_pkg::DOT_W-1:0]  x_full, vb_next;
  logic [ldtc_pkg::LINE_W-1:0] hb_next, gx_next;

  // result register
  logic                        out_valid_q;
  logic [1:0]                  mode_out_q;
  logic [ldtc_pkg::LINE_W-1:0] line_out_q, px_q, py_q;
  logic                        coin_out_q, vb_q, st_q, pv_q, fs_q;
  logic                        dot_acc;

  assign dot_ready_o = ~out_valid_q | res_ready_i;
  assign dot_acc     = dot_valid_i & dot_ready_o;

  assign dot_inc = (dot_q < ldtc_pkg::DOT_MAX) ? dot_q + 9'd1 : dot_q;
  assign hb_next = line_q + 8'd1;
  assign vb_next = {1'b0, line_q} + 9'd1;
  assign x_full  = {1'b0, group_x_q} + 9'd8 - {5'b0, pend_q};
  assign gx_next = group_x_q + 8'd8;

  always_comb begin
    mode_d    = mode_q;
    fetch_d   = fetch_q;
    line_d    = line_q;
    dot_d     = dot_q;
    wait_d    = wait_q;
    group_x_d = group_x_q;
    pend_d    = pend_q;
    coin_d    = coin_q;
    vb = 1'b0; st = 1'b0; pv = 1'b0; fs = 1'b0;
    px = '0;   py = '0;
    if (dot_enable_i) begin
      dot_d = dot_inc;
      unique case (mode_q)
        ldtc_pkg::ST_HBLANK: begin
          if (dot_inc >= ldtc_pkg::DOTS_PER_LINE) begin
            dot_d  = '0;
            line_d = hb_next;
            coin_d = (hb_next == compare_line_q);
            st     = coin_d & irq_coin_q;
            if (hb_next >= ldtc_pkg::VISIBLE_LINES) begin
              mode_d = ldtc_pkg::ST_VBLANK;
              vb     = 1'b1;
              st     = st | irq_vblank_q;
            end else begin
              mode_d = ldtc_pkg::ST_SCAN;
              st     = st | irq_scan_q;
            end
          end
        end
        ldtc_pkg::ST_VBLANK: begin
          if (dot_inc >= ldtc_pkg::DOTS_PER_LINE) begin
            dot_d = '0;
            if (vb_next >= ldtc_pkg::TOTAL_LINES) begin
              line_d = '0;
              fs     = 1'b1;
              mode_d = ldtc_pkg::ST_SCAN;
              st     = irq_scan_q;
            end else begin
              line_d = vb_next[ldtc_pkg::LINE_W-1:0];
            end
            coin_d = (line_d == compare_line_q);
            st     = st | (coin_d & irq_coin_q);
          end
        end
        ldtc_pkg::ST_SCAN: begin
          if (dot_inc >= ldtc_pkg::SCAN_DOTS) begin
            mode_d  = ldtc_pkg::ST_DRAW;
            fetch_d = ldtc_pkg::FP_TILE;
          end
        end
        ldtc_pkg::ST_DRAW: begin
          if (wait_q != 2'd0) begin
            wait_d = wait_q - 2'd1;
          end else if (pend_q == 4'd0) begin
            unique case (fetch_q)
              ldtc_pkg::FP_LOW:   begin fetch_d = ldtc_pkg::FP_HIGH;  wait_d = 2'd1; end
              ldtc_pkg::FP_HIGH:  begin fetch_d = ldtc_pkg::FP_SLEEP; wait_d = 2'd1; end
              ldtc_pkg::FP_SLEEP: begin fetch_d = ldtc_pkg::FP_PUSH;  wait_d = 2'd2; end
              ldtc_pkg::FP_PUSH:  begin fetch_d = ldtc_pkg::FP_TILE;  pend_d = 4'd8; end
              default:            begin fetch_d = ldtc_pkg::FP_LOW;   wait_d = 2'd1; end
            endcase
          end else begin
            if (x_full < ldtc_pkg::VISIBLE_WIDTH) begin
              pv = 1'b1;
              px = x_full[ldtc_pkg::LINE_W-1:0];
              py = line_q;
            end
            pend_d = pend_q - 4'd1;
            if (pend_q == 4'd1) begin
              group_x_d = gx_next;
              if ({1'b0, gx_next} >= ldtc_pkg::VISIBLE_WIDTH) begin
                group_x_d = '0;
                fetch_d   = ldtc_pkg::FP_TILE;
                wait_d    = 2'd0;
                mode_d    = ldtc_pkg::ST_HBLANK;
                st        = irq_hblank_q;
              end
            end
          end
        end
        default: mode_d = ldtc_pkg::ST_SCAN;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ldtc_pkg::ST_SCAN;
      fetch_q   <= ldtc_pkg::FP_TILE;
      line_q    <= '0;
      dot_q     <= '0;
      wait_q    <= '0;
      group_x_q <= '0;
      pend_q    <= '0;
      coin_q    <= 1'b0;
    end else if (dot_acc) begin
      mode_q    <= mode_d;
      fetch_q   <= fetch_d;
      line_q    <= line_d;
      dot_q     <= dot_d;
      wait_q    <= wait_d;
      group_x_q <= group_x_d;
      pend_q    <= pend_d;
      coin_q    <= coin_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (dot_ready_o) begin
      out_valid_q <= dot_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dot_acc) begin
      mode_out_q <= ldtc_pkg::mode_code(mode_d);
      line_out_q <= line_d;
      coin_out_q <= coin_d;
      vb_q       <= vb;
      st_q       <= st;
      pv_q       <= pv;
      px_q       <= px;
      py_q       <= py;
      fs_q       <= fs;
    end
  end

  assign res_valid_o   = out_valid_q;
  assign mode_o        = mode_out_q;
  assign line_o        = line_out_q;
  assign coincidence_o = coin_out_q;
  assign vblank_irq_o  = vb_q;
  assign stat_irq_o    = st_q;
  assign pixel_valid_o = pv_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign frame_start_o = fs_q;

  `LDTC_ASSERT_IMP(a_wait_only_draw, wait_q != 2'd0, mode_q == ldtc_pkg::ST_DRAW)
  `LDTC_ASSERT_IMP(a_pend_only_draw, pend_q != 4'd0, mode_q == ldtc_pkg::ST_DRAW)
  `LDTC_ASSERT_NXT(a_frame_start_scan, dot_acc && fs,
                   line_out_q == '0 && mode_out_q == ldtc_pkg::MODE_CODE_SCAN)
  `LDTC_ASSERT_NXT(a_pixel_in_draw, dot_acc && pv,
                   mode_out_q == ldtc_pkg::MODE_CODE_DRAW ||
                   mode_out_q == ldtc_pkg::MODE_CODE_HBLANK)
  `LDTC_ASSERT_NXT(a_vblank_mode, dot_acc && vb, mode_out_q == ldtc_pkg::MODE_CODE_VBLANK)

endmodule
